// ===== src/dttf_pkg.sv =====
`default_nettype none
package dttf_pkg;

    localparam int MAX_DIGITS_DEF = 8;

    // ASCII codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // single precision scale constants
    localparam logic [31:0] F_CENTI = 32'h3C23D70A;  // 0.01f
    localparam logic [31:0] F_DECI  = 32'h3DCCCCCD;  // 0.1f
    localparam logic [31:0] F_TEN   = 32'h41200000;  // 10.0f
    localparam logic [30:0] F_INF   = {8'hFF, 23'd0};

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_IRND,
        S_SCALE,
        S_MUL,
        S_MRND,
        S_DONE
    } state_t;

    // round to nearest even and pack exponent/fraction, overflow to infinity
    function automatic logic [30:0] rne_pack(input logic signed [9:0] e10,
                                             input logic [23:0] m,
                                             input logic g, input logic s);
        logic inc;
        logic [24:0] m25;
        logic signed [9:0] e;
        logic [22:0] frac;
        inc  = g & (s | m[0]);
        m25  = {1'b0, m} + {24'd0, inc};
        e    = e10 + {9'd0, m25[24]};
        frac = m25[24] ? m25[23:1] : m25[22:0];
        if (e >= 10'sd255) begin
            rne_pack = F_INF;
        end else begin
            rne_pack = {e[7:0], frac};
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/decimal_text_to_float.sv =====
// A character that does not end a number only updates the parse registers.
// A terminator of a nonzero number starts the shift-by-one normalizer, then the
// integer rounding and the multiplications by the shared multiplier (up to 127
// for large exponents), then the result goes to the output register.
// Throughput: one character per cycle while parsing; none during conversion.
// Reset: synchronous active-low aresetn clears all parse and control state.
`default_nettype none
module decimal_text_to_float #(
    parameter int MAX_DIGITS = dttf_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // character
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // valid_res, value_bits[31:0], chars_used[7:0], 0
);
    import dttf_pkg::*;

    localparam int MW = $clog2(10 ** MAX_DIGITS);

    state_t state_reg, state_next;

    // parse state
    logic          neg_reg, neg_next;
    logic          past_reg, past_next;
    logic          point_reg, point_next;
    logic [7:0]    dc_reg, dc_next;
    logic [MW-1:0] mant_reg, mant_next;
    logic signed [7:0] dexp_reg, dexp_next;
    logic [7:0]    cc_reg, cc_next;

    // conversion state
    logic          cneg_reg, cvalid_reg;
    logic [7:0]    cchars_reg;
    logic [31:0]   nrm_reg;
    logic [7:0]    ie_reg;
    logic signed [7:0] e_reg;
    logic [30:0]   acc_reg;
    logic [30:0]   cst_reg;

    // output register
    logic          mv_reg;
    logic [47:0]   md_reg;

    logic [7:0] d;
    logic is_dig, acc_in, term;
    logic [30:0] mul_res;

    dttf_fmul u_fmul (
        .aclk (aclk),
        .load (state_reg == S_MUL),
        .a    (acc_reg),
        .b    (cst_reg),
        .res  (mul_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    // character decode
    always_comb begin
        d      = s_tdata - CH_ZERO;
        is_dig = (d <= 8'd9);
        term   = 1'b0;
        neg_next = neg_reg; past_next = past_reg; point_next = point_reg;
        dc_next = dc_reg; mant_next = mant_reg; dexp_next = dexp_reg;
        cc_next = cc_reg;
        if (!past_reg && (s_tdata == CH_MINUS || s_tdata == CH_PLUS)) begin
            past_next = 1'b1;
            neg_next  = (s_tdata == CH_MINUS);
            cc_next   = (cc_reg == 8'hFF) ? cc_reg : cc_reg + 8'd1;
        end else if (is_dig) begin
            past_next = 1'b1;
            dc_next   = (dc_reg == 8'hFF) ? dc_reg : dc_reg + 8'd1;
            if (dc_next <= 8'(MAX_DIGITS)) begin
                if (point_reg) begin
                    dexp_next = dexp_reg - 8'sd1;
                end
                mant_next = (mant_reg << 3) + (mant_reg << 1) + MW'(d);
            end else if (!point_reg && dexp_reg < 8'sd127) begin
                dexp_next = dexp_reg + 8'sd1;
            end
            cc_next = (cc_reg == 8'hFF) ? cc_reg : cc_reg + 8'd1;
        end else if (s_tdata == CH_POINT && !point_reg) begin
            past_next  = 1'b1;
            point_next = 1'b1;
            cc_next    = (cc_reg == 8'hFF) ? cc_reg : cc_reg + 8'd1;
        end else begin
            term = 1'b1;
        end
    end

    // parse registers
    always_ff @(posedge aclk) begin
        if (!aresetn || (acc_in && term)) begin
            neg_reg <= 1'b0; past_reg <= 1'b0; point_reg <= 1'b0;
            dc_reg <= '0; mant_reg <= '0; dexp_reg <= '0; cc_reg <= '0;
        end else if (acc_in) begin
            neg_reg <= neg_next; past_reg <= past_next; point_reg <= point_next;
            dc_reg <= dc_next; mant_reg <= mant_next; dexp_reg <= dexp_next;
            cc_reg <= cc_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (acc_in && term) begin
                    state_next = (dc_reg == 8'd0 || mant_reg == '0) ? S_DONE : S_NORM;
                end
            end
            S_NORM:  state_next = nrm_reg[31] ? S_IRND : S_NORM;
            S_IRND:  state_next = S_SCALE;
            S_SCALE: state_next = (e_reg == 8'sd0) ? S_DONE : S_MUL;
            S_MUL:   state_next = S_MRND;
            S_MRND:  state_next = S_SCALE;
            S_DONE:  state_next = (!mv_reg || m_tready) ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // conversion datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (acc_in && term) begin
                    cneg_reg   <= neg_reg;
                    cvalid_reg <= (dc_reg != 8'd0);
                    cchars_reg <= cc_reg;
                    nrm_reg    <= 32'(mant_reg);
                    ie_reg     <= 8'd158;
                    e_reg      <= dexp_reg;
                    acc_reg    <= '0;
                end
            end
            S_NORM: begin
                if (!nrm_reg[31]) begin
                    nrm_reg <= nrm_reg << 1;
                    ie_reg  <= ie_reg - 8'd1;
                end
            end
            S_IRND: begin
                acc_reg <= rne_pack($signed({2'b0, ie_reg}), nrm_reg[31:8],
                                    nrm_reg[7], |nrm_reg[6:0]);
            end
            S_SCALE: begin
                if (e_reg <= -8'sd2) begin
                    cst_reg <= F_CENTI[30:0];
                    e_reg   <= e_reg + 8'sd2;
                end else if (e_reg < 8'sd0) begin
                    cst_reg <= F_DECI[30:0];
                    e_reg   <= 8'sd0;
                end else if (e_reg > 8'sd0) begin
                    cst_reg <= F_TEN[30:0];
                    e_reg   <= e_reg - 8'sd1;
                end
            end
            S_MUL:  ;
            S_MRND: acc_reg <= mul_res;
            S_DONE: ;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (state_reg == S_DONE && (!mv_reg || m_tready)) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!mv_reg || m_tready)) begin
            md_reg <= {7'd0, cchars_reg,
                       cvalid_reg ? {cneg_reg, acc_reg} : 32'd0, cvalid_reg};
        end
    end

endmodule
`default_nettype wire

// ===== src/dttf_fmul.sv =====
`default_nettype none
// single precision multiply of positive normal operands, product registered,
// normalize and round on the next cycle
module dttf_fmul (
    input  wire logic        aclk,
    input  wire logic        load,
    input  wire logic [30:0] a,
    input  wire logic [30:0] b,
    output logic      [30:0] res
);
    import dttf_pkg::*;

    logic [47:0] prod_reg;
    logic signed [9:0] esum_reg;
    logic inf_reg;
    logic signed [9:0] e10;

    // significand product
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= {1'b1, a[22:0]} * {1'b1, b[22:0]};
            esum_reg <= $signed({2'b0, a[30:23]}) + $signed({2'b0, b[30:23]})
                        - 10'sd127;
            inf_reg  <= (a[30:23] == 8'hFF);
        end
    end

    // normalize and round
    always_comb begin
        e10 = esum_reg + {9'd0, prod_reg[47]};
        if (inf_reg) begin
            res = F_INF;
        end else if (prod_reg[47]) begin
            res = rne_pack(e10, prod_reg[47:24], prod_reg[23], |prod_reg[22:0]);
        end else begin
            res = rne_pack(e10, prod_reg[46:23], prod_reg[22], |prod_reg[21:0]);
        end
    end

endmodule
`default_nettype wire

// ===== sim/decimal_text_to_float_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module decimal_text_to_float_tb;
    import dttf_pkg::*;

    localparam int MAX_DIG     = MAX_DIGITS_DEF;
    localparam int QUIET_TAIL  = 120;   // last transactions sent without idling
    localparam int LONG_HOLD   = 700;   // receiver hold-off, in cycles

    typedef struct packed {
        logic        ok;
        logic [31:0] bits;
        logic [7:0]  used;
    } number_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // character
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // valid_res, value_bits[31:0], chars_used[7:0], 0

    decimal_text_to_float dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [7:0] text_q[$];
    number_t    number_q[$];
    int         mismatches = 0;
    int         numbers_seen = 0;

    // parser state of the predictor
    logic              sign_neg;
    logic              begun;
    logic              has_point;
    logic [7:0]        ndigits;
    logic [26:0]       int_part;
    logic signed [8:0] dec_exp;
    logic [7:0]        nchars;

    // clock and reset
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // round a normalized 24-bit significand with guard/sticky, overflow to infinity
    function automatic logic [31:0] pack_rne(input logic sgn, input int e,
                                             input logic [23:0] m,
                                             input logic g, input logic st);
        logic [24:0] r;
        r = {1'b0, m} + ((g && (st || m[0])) ? 25'd1 : 25'd0);
        if (r[24]) begin
            r = r >> 1;
            e = e + 1;
        end
        if (e >= 255)
            return {sgn, 8'hFF, 23'd0};
        return {sgn, e[7:0], r[22:0]};
    endfunction

    function automatic logic [31:0] int_to_single(input logic [26:0] v);
        int          k;
        logic [50:0] w;
        // zero has no leading one
        if (v == '0)
            return 32'd0;
        k = 0;
        for (int i = 0; i < 27; i++)
            if (v[i]) k = i;
        // place the leading one at bit 50, significand in [50:27]
        w = {24'd0, v} << (50 - k);
        return pack_rne(1'b0, 127 + k, w[50:27], w[26], |w[25:0]);
    endfunction

    function automatic logic [31:0] mul_single(input logic [31:0] a, input logic [31:0] b);
        logic [47:0] p;
        int          e;
        if (a[30:23] == 8'hFF)
            return {a[31] ^ b[31], 8'hFF, 23'd0};
        p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        e = int'(a[30:23]) + int'(b[30:23]) - 127;
        if (p[47])
            return pack_rne(a[31] ^ b[31], e + 1, p[47:24], p[23], |p[22:0]);
        return pack_rne(a[31] ^ b[31], e, p[46:23], p[22], |p[21:0]);
    endfunction

    task automatic clear_parse();
        sign_neg  = 1'b0;
        begun     = 1'b0;
        has_point = 1'b0;
        ndigits   = '0;
        int_part  = '0;
        dec_exp   = '0;
        nchars    = '0;
    endtask

    // advance the parser by one character, queue a number on a terminator
    task automatic parse_char(input logic [7:0] ch);
        logic [7:0]  d;
        logic [31:0] f;
        int          e;
        number_t     n;
        if (!begun) begin
            begun = 1'b1;
            if (ch == CH_MINUS || ch == CH_PLUS) begin
                sign_neg = (ch == CH_MINUS);
                if (nchars != 8'hFF) nchars++;
                return;
            end
        end
        d = ch - CH_ZERO;
        if (d <= 8'd9) begin
            if (ndigits != 8'hFF) ndigits++;
            if (ndigits <= MAX_DIG) begin
                if (has_point) dec_exp--;
                int_part = 27'(int_part * 27'd10 + {19'd0, d});
            end else if (!has_point && dec_exp < 127) begin
                dec_exp++;
            end
            if (nchars != 8'hFF) nchars++;
            return;
        end
        if (ch == CH_POINT && !has_point) begin
            has_point = 1'b1;
            if (nchars != 8'hFF) nchars++;
            return;
        end
        n.ok   = (ndigits != 0);
        n.bits = '0;
        n.used = nchars;
        if (n.ok) begin
            f = int_to_single(int_part);
            e = int'(dec_exp);
            if (int_part != 0) begin
                while (e <= -2) begin
                    f = mul_single(f, F_CENTI);
                    e += 2;
                end
                if (e < 0) begin
                    f = mul_single(f, F_DECI);
                end else begin
                    while (e > 0) begin
                        f = mul_single(f, F_TEN);
                        e--;
                    end
                end
            end
            if (sign_neg) f[31] = ~f[31];
            n.bits = f;
        end
        number_q.push_back(n);
        clear_parse();
    endtask

    // stimulus helpers
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_ZERO + 8'd9) || c == CH_POINT);
        return c;
    endfunction

    task automatic push_random_number();
        int nd;
        int pt;
        case ($urandom_range(0, 3))
            0: text_q.push_back(CH_MINUS);
            1: text_q.push_back(CH_PLUS);
            default: ;
        endcase
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
        pt = ($urandom_range(0, 1) != 0) ? $urandom_range(0, nd) : -1;
        for (int i = 0; i <= nd; i++) begin
            if (i == pt) text_q.push_back(CH_POINT);
            if (i < nd) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        text_q.push_back(pick_terminator());
    endtask

    initial begin
        clear_parse();
        // directed: extremes, signs, points, saturations
        push_text("0 ");
        push_text("-0;");
        push_text("+12.5x");
        push_text("99999999,");
        push_text("-123456789012 ");
        push_text("1.2.");
        push_text("-+");
        push_text("..");
        push_text(".00000001/");
        push_text("0.5e");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        for (int i = 0; i < 300; i++) text_q.push_back(CH_ZERO + 8'd9);
        text_q.push_back(8'h20);
        // random: mostly well-formed numbers, some noise
        while (text_q.size() < 1000) begin
            if ($urandom_range(0, 5) == 0)
                text_q.push_back(8'($urandom_range(0, 255)));
            else
                push_random_number();
        end
        text_q.push_back(8'h20);
    end

    // sender
    int send_idle = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                parse_char(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    s_tvalid  <= 1'b0;
                end else if (text_q.size() > 0) begin
                    s_tdata  <= text_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (text_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                        send_idle <= $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and result check
    int   recv_idle = 0;
    logic long_done = 1'b0;
    always @(posedge aclk) begin
        number_t got;
        number_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[32:1], m_tdata[40:33]};
                numbers_seen++;
                if (number_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result ok=%0b bits=%h used=%0d",
                                 got.ok, got.bits, got.used);
                end else begin
                    want = number_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp ok=%0b bits=%h used=%0d, got ok=%0b bits=%h used=%0d",
                                     numbers_seen, want.ok, want.bits, want.used,
                                     got.ok, got.bits, got.used);
                    end
                end
            end
            if (!long_done && numbers_seen == 20) begin
                long_done = 1'b1;
                recv_idle <= LONG_HOLD;
                m_tready  <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (text_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    recv_idle <= $urandom_range(1, 17);
            end
        end
    end

    // end of run
    initial begin
        @(posedge aresetn);
        wait (text_q.size() == 0 && !s_tvalid);
        wait (number_q.size() == 0);
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && number_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/dttf_pkg.sv
src/dttf_fmul.sv
src/decimal_text_to_float.sv
sim/decimal_text_to_float_tb.sv
